### hdl/modinv_pkg.sv
// Package for the modular inverse block: widths, word types and sequencer states.
package modinv_pkg;

	localparam int DATA_W = 32;
	localparam int WIDTH  = 32;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] modulus;
	} item_t;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] inverse;
	} result_t;

	typedef struct packed {
		logic start;
		logic take;
	} ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_SUB,
		ST_FIX,
		ST_DONE
	} state_t;

endpackage

### hdl/modular_inverse.sv
// Modular inverse: one value and modulus in, found flag and inverse out, one word per item.
// Each item runs through extended Euclid, built from one shared shift, compare and subtract
// unit: every quotient is formed bit by bit by shifting the divisor up until it just fits
// and then subtracting it back down. An item with a modulus below 2 or a zero value skips
// the shift and subtract steps and goes straight to the done state. The item side stalls
// while the engine works; a finished word sits in the result register so the next item
// is taken as soon as the engine has handed it over.
module modular_inverse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  modinv_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output modinv_pkg::result_t result
);
	import modinv_pkg::*;

	ctl_t    ctl;
	stat_t   stat;
	result_t core_result;
	logic    out_valid_q;
	result_t out_q;

	assign item_stall = stat.busy;
	assign ctl.start  = item_valid && !stat.busy;
	assign ctl.take   = !out_valid_q || !result_stall;

	modinv_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.item   (item),
		.stat   (stat),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && ctl.take) begin
			out_q <= core_result;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### hdl/modinv_core.sv
// Shift-subtract extended Euclid engine with its sequencer.
module modinv_core (
	input  logic              clk,
	input  logic              arst_n,
	input  modinv_pkg::ctl_t  ctl,
	input  modinv_pkg::item_t item,
	output modinv_pkg::stat_t stat,
	output modinv_pkg::result_t result
);
	import modinv_pkg::*;

	state_t state_q, state_d;

	logic        [WIDTH-1:0] m_q, rp_q, rc_q, rs_q;
	logic signed [WIDTH:0]   tp_q, tc_q, ts_q;
	logic                    found_q;
	logic        [WIDTH-1:0] inv_q;

	logic        [WIDTH-1:0] a_in, m_in;
	logic                    can_shift;
	logic                    ge;
	logic        [WIDTH-1:0] rp_new;
	logic signed [WIDTH:0]   tp_new;
	logic                    last_digit;
	logic signed [WIDTH:0]   tp_fix;

	assign a_in       = item.value[WIDTH-1:0];
	assign m_in       = item.modulus[WIDTH-1:0];
	assign can_shift  = !rs_q[WIDTH-1] && ({rs_q, 1'b0} <= {1'b0, rp_q});
	assign ge         = rs_q <= rp_q;
	assign rp_new     = ge ? rp_q - rs_q : rp_q;
	assign tp_new     = ge ? tp_q - ts_q : tp_q;
	assign last_digit = rs_q == rc_q;
	assign tp_fix     = tp_q[WIDTH] ? tp_q + $signed({1'b0, m_q}) : tp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		stat.busy = 1'b1;
		stat.done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				stat.busy = 1'b0;
				if (ctl.start) begin
					if (m_in < WIDTH'(2) || a_in == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_ALIGN;
					end
				end
			end
			ST_ALIGN: begin
				if (!can_shift) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				if (last_digit) begin
					state_d = (rp_new == '0) ? ST_FIX : ST_ALIGN;
				end
			end
			ST_FIX: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				stat.done = 1'b1;
				if (ctl.take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					m_q     <= m_in;
					rp_q    <= m_in;
					rc_q    <= a_in;
					rs_q    <= a_in;
					tp_q    <= '0;
					tc_q    <= (WIDTH+1)'(1);
					ts_q    <= (WIDTH+1)'(1);
					found_q <= 1'b0;
					inv_q   <= '0;
				end
			end
			ST_ALIGN: begin
				if (can_shift) begin
					rs_q <= {rs_q[WIDTH-2:0], 1'b0};
					ts_q <= ts_q <<< 1;
				end
			end
			ST_SUB: begin
				if (last_digit) begin
					rp_q <= rc_q;
					rc_q <= rp_new;
					rs_q <= rp_new;
					tp_q <= tc_q;
					tc_q <= tp_new;
					ts_q <= tp_new;
				end else begin
					rp_q <= rp_new;
					tp_q <= tp_new;
					rs_q <= rs_q >> 1;
					ts_q <= ts_q >>> 1;
				end
			end
			ST_FIX: begin
				if (rp_q == WIDTH'(1)) begin
					found_q <= 1'b1;
					inv_q   <= tp_fix[WIDTH-1:0];
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign result.found   = found_q;
	assign result.inverse = DATA_W'(inv_q);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == ST_IDLE)
		else $error("start while engine busy");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALIGN || state_q == ST_SUB) |-> rc_q != '0)
		else $error("zero divisor in engine");

	a_shift_ge_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALIGN || state_q == ST_SUB) |-> rs_q >= rc_q)
		else $error("shifted divisor below divisor");

	a_inverse_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && found_q) |-> (inv_q != '0 && inv_q < m_q))
		else $error("inverse out of range");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !found_q) |-> inv_q == '0)
		else $error("nonzero inverse without found");

endmodule

### bench/tb.sv
// Testbench for modular_inverse: directed and random words checked against an inline predictor.
module tb;
	import modinv_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 4 * WIDTH;
	localparam int IDLE_MAX     = 4;

	typedef struct {
		item_t   src;
		result_t want;
	} pending_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	pending_t pending_inverses[$];
	pending_t oldest;
	int       mismatches    = 0;
	int       words_sent    = 0;
	int       results_seen  = 0;
	int       found_count   = 0;
	int       result_hold   = 0;
	bit       idle_on       = 1'b1;

	modular_inverse dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic result_t inverse_of(item_t w);
		longint unsigned mask;
		longint unsigned m;
		longint unsigned a;
		longint          r_old, r_new, t_old, t_new, q, r_nxt, t_nxt;
		result_t         res;
		res   = '0;
		mask  = (64'd1 << WIDTH) - 64'd1;
		m     = {32'd0, w.modulus} & mask;
		a     = {32'd0, w.value} & mask;
		if (m < 2)
			return res;
		a     = a % m;
		r_old = m;
		r_new = a;
		t_old = 0;
		t_new = 1;
		while (r_new != 0) begin
			q     = r_old / r_new;
			r_nxt = r_old - q * r_new;
			t_nxt = t_old - q * t_new;
			r_old = r_new;
			r_new = r_nxt;
			t_old = t_new;
			t_new = t_nxt;
		end
		if (r_old != 1)
			return res;
		if (t_old < 0)
			t_old = t_old + longint'(m);
		if (t_old >= longint'(m))
			t_old = t_old - longint'(m);
		res.found   = 1'b1;
		res.inverse = t_old[DATA_W-1:0];
		return res;
	endfunction

	function automatic item_t make_item(logic [DATA_W-1:0] v, logic [DATA_W-1:0] m);
		item_t w;
		w.value   = v;
		w.modulus = m;
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
			logic [DATA_W-1:0] want, item_t src);
		$display("mismatch %s: got %h want %h (value %h modulus %h)",
			what, got, want, src.value, src.modulus);
		mismatches++;
	endtask

	// Drives one word; returns right after the edge that accepts it.
	task automatic send_word(item_t w);
		int gap;
		pending_t p;
		if (words_sent % 40 == 0)
			idle_on = ($urandom_range(0, 2) != 0);
		gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do
			@(posedge clk);
		while (item_stall);
		p.src  = w;
		p.want = inverse_of(w);
		if (p.want.found)
			found_count++;
		pending_inverses.push_back(p);
		words_sent++;
	endtask

	always @(negedge clk) begin
		if (result_valid && result_hold > 0) begin
			result_stall <= 1'b1;
			result_hold  = result_hold - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_inverses.size() == 0) begin
				report_mismatch("unexpected word", result.inverse, '0, '0);
			end else begin
				oldest = pending_inverses.pop_front();
				if (result.found !== oldest.want.found)
					report_mismatch("found", {31'd0, result.found},
						{31'd0, oldest.want.found}, oldest.src);
				if (result.inverse !== oldest.want.inverse)
					report_mismatch("inverse", result.inverse, oldest.want.inverse,
						oldest.src);
			end
			results_seen++;
			result_hold = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d words outstanding", pending_inverses.size());
		$display("FAIL");
		$finish;
	end

	task automatic test_directed();
		// degenerate moduli
		send_word(make_item(32'd5, 32'd0));
		send_word(make_item(32'd5, 32'd1));
		send_word(make_item(32'd0, 32'd0));
		send_word(make_item(32'hFFFF_FFFF, 32'd0));
		send_word(make_item(32'd1, 32'd1));
		// smallest real modulus
		send_word(make_item(32'd0, 32'd2));
		send_word(make_item(32'd1, 32'd2));
		send_word(make_item(32'hFFFF_FFFF, 32'd2));
		// values congruent to zero modulo 7, then two that are not
		send_word(make_item(32'd0, 32'd7));
		send_word(make_item(32'd7, 32'd7));
		send_word(make_item(32'd14, 32'd7));
		send_word(make_item(32'd3, 32'd7));
		send_word(make_item(32'd6, 32'd7));
		// gcd above one, then a coprime pair
		send_word(make_item(32'd6, 32'd9));
		send_word(make_item(32'd4, 32'd10));
		send_word(make_item(32'd3, 32'd10));
		// extremes of both fields
		send_word(make_item(32'd1, 32'hFFFF_FFFF));
		send_word(make_item(32'hFFFF_FFFE, 32'hFFFF_FFFF));
		send_word(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_word(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFE));
		send_word(make_item(32'hFFFF_FFFF, 32'd4294967291));
		send_word(make_item(32'd2, 32'd4294967291));
		// longest Euclid chains: consecutive Fibonacci numbers, then a power-of-two modulus
		send_word(make_item(32'd1836311903, 32'd2971215073));
		send_word(make_item(32'd2971215073, 32'd1836311903));
		send_word(make_item(32'd12345, 32'h8000_0000));
	endtask

	task automatic test_wide_random(int n);
		logic [DATA_W-1:0] m;
		repeat (n) begin
			m = ($urandom_range(0, 7) == 0) ? 32'd4294967291 : $urandom;
			send_word(make_item($urandom, m));
		end
	endtask

	task automatic test_small_moduli(int n);
		repeat (n)
			send_word(make_item($urandom, $urandom_range(2, 255)));
	endtask

	task automatic test_power_of_two(int n);
		logic [DATA_W-1:0] m;
		repeat (n) begin
			m = 32'd1 << $urandom_range(1, 31);
			send_word(make_item($urandom | {31'd0, ($urandom_range(0, 3) != 0)}, m));
		end
	endtask

	task automatic test_shared_factor(int n);
		logic [DATA_W-1:0] f;
		repeat (n) begin
			f = $urandom_range(2, 65535);
			send_word(make_item(f * $urandom_range(0, 65535), f * $urandom_range(1, 65535)));
		end
	endtask

	task automatic test_reduction(int n);
		logic [DATA_W-1:0] m;
		repeat (n) begin
			m = $urandom_range(2, 65536);
			if ($urandom_range(0, 1))
				send_word(make_item(m * $urandom_range(1, 65535) + 1, m));
			else
				send_word(make_item($urandom, m));
		end
	endtask

	task automatic test_degenerate(int n);
		logic [DATA_W-1:0] m;
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: begin
					send_word(make_item($urandom, $urandom_range(0, 1)));
				end
				1: begin
					m = $urandom_range(2, 65535);
					send_word(make_item(m * $urandom_range(0, 65535), m));
				end
				default: begin
					send_word(make_item(32'd0, $urandom));
				end
			endcase
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_wide_random(600);
		test_small_moduli(300);
		test_power_of_two(250);
		test_shared_factor(250);
		test_reduction(200);
		test_degenerate(100);

		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_inverses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words sent: directed, wide, small, power-of-two,", words_sent);
		$display("shared-factor, reduced and degenerate; %0d results checked, %0d with an inverse",
			results_seen, found_count);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
hdl/modinv_pkg.sv
hdl/modinv_core.sv
hdl/modular_inverse.sv
bench/tb.sv
